[sv/chm_pkg.sv]
// Package for the chained hash map: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package chm_pkg;
   localparam int MaxBuckets = 256;
   localparam int PoolNodes  = 512;
   localparam int BktW  = $clog2(MaxBuckets);
   localparam int NodeW = $clog2(PoolNodes);
   localparam int LinkW = $clog2(PoolNodes + 1);
   localparam int CntW  = $clog2(MaxBuckets + 1);

   localparam logic [1:0] MODE_GET = 2'd0;
   localparam logic [1:0] MODE_TRY = 2'd1;
   localparam logic [1:0] MODE_PUT = 2'd2;

   typedef logic [LinkW-1:0] link_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic        hit;
      logic        pool_full;
   } rsp_type;
endpackage

[sv/chm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module chm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

[sv/chm_mod.sv]
// Sequential key modulo bucket count: restoring remainder, one bit a cycle.
// Depends on chm_pkg.
`timescale 1ns / 1ps
module chm_mod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [63:0]             key,
   input  logic [chm_pkg::CntW-1:0] divisor,
   output logic                    done,
   output logic [chm_pkg::BktW-1:0] remainder
);
   import chm_pkg::*;

   logic [63:0]   shift_ff, shift_in;
   logic [CntW:0] rem_ff, rem_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [CntW:0] trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done     = 1'b0;
      trial    = {rem_ff[CntW-1:0], shift_ff[63]};
      if (start) begin
         shift_in = key;
         rem_in   = '0;
         cnt_in   = 7'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift one key bit in, subtract where it fits
         shift_in = {shift_ff[62:0], 1'b0};
         rem_in   = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in   = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end else if (cnt_ff == 7'd64) begin
         done   = 1'b1;
         cnt_in = 7'd0;
      end
   end

   assign remainder = rem_ff[BktW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end
endmodule

[sv/chained_hash_map_unit.sv]
// Top level of the chained hash map: control sequencer, bucket and node RAMs.
// Depends on chm_pkg, chm_ram, chm_mod.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake       | Payload
// req     | in        | tvalid/tready   | tdata: mode, key, value
// rsp     | out       | tvalid/tready   | tdata: result_value, hit, pool_full
// csr     | in        | APB, pready = 1 | bucket_count at address 0
//
// One item at a time. A valid item first runs the bucket modulo (one key bit a
// cycle), then reads the bucket head; a lookup reads each chain node visited from
// the node RAM, an insert writes the node and head back. Reset is synchronous; after
// reset a clearing pass empties all bucket heads, during which
// no transfer is taken on req. A finished result moves to the output register;
// the next item is taken while it waits there, and an item that finishes
// while that register is still full holds until the register drains.
module chained_hash_map_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // mode[1:0], key[65:2], value[129:66], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // result_value[63:0], hit[64], pool_full[65], pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import chm_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_HEAD  = 3'd3;
   localparam logic [2:0] S_NODE  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [8:0]       bcount_ff;
   logic [1:0]       mode_ff, mode_in;
   logic [63:0]      key_ff, key_in;
   logic [63:0]      value_ff, value_in;
   logic [BktW-1:0]  bucket_ff, bucket_in;
   link_type         cur_ff, cur_in;
   link_type         head_ff, head_in;
   logic [LinkW:0]   steps_ff, steps_in;
   logic [LinkW-1:0] used_ff, used_in;
   logic [BktW-1:0]  clr_ff, clr_in;
   rsp_type          rsp_ff, rsp_in;
   rsp_type          rspo_ff, rspo_in;
   logic             rspv_ff, rspv_in;

   // mod unit
   logic            mod_start, mod_done;
   logic [BktW-1:0] mod_rem;
   logic [CntW-1:0] divisor;

   // RAM ports
   logic            head_we;
   logic [BktW-1:0] head_addr;
   link_type        head_wdata, head_rdata;
   logic            node_we;
   logic [NodeW-1:0] node_addr;
   logic [127+LinkW:0] node_wdata, node_rdata;
   logic [63:0]     nd_key, nd_value;
   link_type        nd_link;

   // saturate the register into 1..MaxBuckets
   always_comb begin
      if (bcount_ff == 9'd0) begin
         divisor = CntW'(1);
      end else if ({23'd0, bcount_ff} > 32'(MaxBuckets)) begin
         divisor = CntW'(MaxBuckets);
      end else begin
         divisor = CntW'(bcount_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {23'd0, bcount_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= 9'd256;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0) begin
         bcount_ff <= csr_pwdata[8:0];
      end
   end

   chm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .key       (key_ff),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   chm_ram #(.Width(LinkW), .Depth(MaxBuckets)) u_heads (
      .clock (clock),
      .we    (head_we),
      .addr  (head_addr),
      .wdata (head_wdata),
      .rdata (head_rdata)
   );

   chm_ram #(.Width(128 + LinkW), .Depth(PoolNodes)) u_nodes (
      .clock (clock),
      .we    (node_we),
      .addr  (node_addr),
      .wdata (node_wdata),
      .rdata (node_rdata)
   );

   assign nd_key   = node_rdata[63:0];
   assign nd_value = node_rdata[127:64];
   assign nd_link  = node_rdata[127+LinkW:128];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = {6'd0, rspo_ff.pool_full, rspo_ff.hit, rspo_ff.result_value};

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      bucket_in  = bucket_ff;
      cur_in     = cur_ff;
      head_in    = head_ff;
      steps_in   = steps_ff;
      used_in    = used_ff;
      clr_in     = clr_ff;
      rsp_in     = rsp_ff;
      rspo_in    = rspo_ff;
      rspv_in    = rspv_ff;
      mod_start  = 1'b0;
      head_we    = 1'b0;
      head_addr  = bucket_ff;
      head_wdata = '0;
      node_we    = 1'b0;
      node_addr  = cur_ff[NodeW-1:0] - NodeW'(1);
      node_wdata = {head_ff, value_ff, key_ff};

      if (rspv_ff && rsp_tready) begin
         rspv_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // sweep every bucket head to empty
            head_we   = 1'b1;
            head_addr = clr_ff;
            clr_in    = clr_ff + BktW'(1);
            if (clr_ff == BktW'(MaxBuckets - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in  = req_tdata[1:0];
               key_in   = req_tdata[65:2];
               value_in = req_tdata[129:66];
               rsp_in   = '0;
               if (req_tdata[1:0] inside {MODE_GET, MODE_TRY, MODE_PUT}) begin
                  state_in = S_MOD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MOD: begin
            if (steps_ff == '0) begin
               mod_start = 1'b1;
               steps_in  = (LinkW+1)'(1);
            end else if (mod_done) begin
               bucket_in = mod_rem;
               steps_in  = '0;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            // issue head read, capture it in the next cycle
            if (steps_ff == '0) begin
               steps_in = (LinkW+1)'(1);
            end else begin
               head_in  = head_rdata;
               cur_in   = head_rdata;
               steps_in = '0;
               state_in = (mode_ff == MODE_PUT) ? S_LINK : S_NODE;
            end
         end
         S_NODE: begin
            // stop at a null or out-of-range link or the step limit; else hold the node address for the read
            if (cur_ff == '0 || {1'b0, cur_ff} > (LinkW+1)'(PoolNodes) ||
                steps_ff >= (LinkW+1)'(PoolNodes)) begin
               state_in = (mode_ff == MODE_TRY) ? S_LINK : S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (nd_key == key_ff) begin
               rsp_in.result_value = nd_value;
               rsp_in.hit          = 1'b1;
               state_in            = S_DONE;
            end else begin
               cur_in   = nd_link;
               steps_in = steps_ff + (LinkW+1)'(1);
               state_in = S_NODE;
            end
         end
         S_LINK: begin
            if ({1'b0, used_ff} >= (LinkW+1)'(PoolNodes)) begin
               rsp_in.pool_full = 1'b1;
            end else begin
               node_we    = 1'b1;
               node_addr  = used_ff[NodeW-1:0];
               head_we    = 1'b1;
               head_wdata = used_ff + LinkW'(1);
               used_in    = used_ff + LinkW'(1);
               rsp_in.result_value = value_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand the result over once the output register is free or draining
            if (!rspv_ff || rsp_tready) begin
               rspo_in  = rsp_ff;
               rspv_in  = 1'b1;
               steps_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         used_ff  <= '0;
         rspv_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
         rspv_ff  <= rspv_in;
         steps_ff <= steps_in;
      end
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      bucket_ff <= bucket_in;
      cur_ff    <= cur_in;
      head_ff   <= head_in;
      rsp_ff    <= rsp_in;
      rspo_ff   <= rspo_in;
   end
endmodule

[tb/chained_hash_map_unit_tb.sv]
// Self-checking testbench for chained_hash_map_unit: random and directed map traffic
// with a behavioral map predictor. Depends on chm_pkg and the unit's RTL.
`timescale 1ns / 1ps
module chained_hash_map_unit_tb;
   import chm_pkg::*;

   localparam int CycleLimit = 20000000;

   typedef struct {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [63:0] value;
   } map_op_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [0:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   chained_hash_map_unit i_dut (.*);

   // Predictor state: a copy of the map. Links hold node+1, 0 means empty.
   int unsigned map_buckets;
   int unsigned map_heads [MaxBuckets];
   logic [63:0] map_keys [PoolNodes];
   logic [63:0] map_values [PoolNodes];
   int unsigned map_links [PoolNodes];
   int unsigned map_used;

   map_op_type  pending_ops[$];
   rsp_type     expected_rsps[$];
   logic [63:0] known_keys[$];
   int          error_count;
   int          cycle_count;
   bit          op_taken;
   int          burst_left;
   int          gap_left;
   int          stall_kind;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned find_node(logic [63:0] key, int unsigned bkt);
      int unsigned cur;
      int unsigned steps;
      cur = map_heads[bkt];
      steps = 0;
      while (cur != 0 && steps < PoolNodes) begin
         if (map_keys[cur-1] == key) return cur;
         cur = map_links[cur-1];
         steps++;
      end
      return 0;
   endfunction

   // Apply one operation to the predictor map and return its result.
   function automatic rsp_type apply_map_op(map_op_type op);
      rsp_type     r;
      int unsigned n;
      int unsigned bkt;
      int unsigned found;
      bit          link_it;
      r = '0;
      n = map_buckets;
      if (n == 0) n = 1;
      if (n > MaxBuckets) n = MaxBuckets;
      bkt = int'(op.key % 64'(n));
      link_it = 1'b0;
      if (op.mode == MODE_GET || op.mode == MODE_TRY) begin
         found = find_node(op.key, bkt);
         if (found != 0) begin
            r.result_value = map_values[found-1];
            r.hit = 1'b1;
         end else if (op.mode == MODE_TRY) begin
            link_it = 1'b1;
         end
      end else if (op.mode == MODE_PUT) begin
         link_it = 1'b1;
      end
      if (link_it) begin
         if (map_used >= PoolNodes) begin
            r.pool_full = 1'b1;
         end else begin
            map_keys[map_used] = op.key;
            map_values[map_used] = op.value;
            map_links[map_used] = map_heads[bkt];
            map_heads[bkt] = map_used + 1;
            map_used++;
            r.result_value = op.value;
            known_keys.push_back(op.key);
         end
      end
      return r;
   endfunction

   function automatic map_op_type random_map_op();
      map_op_type op;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 35) op.mode = MODE_GET;
      else if (pick < 65) op.mode = MODE_TRY;
      else if (pick < 90) op.mode = MODE_PUT;
      else op.mode = 2'd3;
      pick = $urandom_range(99);
      if (pick < 50 && known_keys.size() > 0)
         op.key = known_keys[$urandom_range(known_keys.size()-1)];
      else if (pick < 70)
         op.key = 64'($urandom_range(1000));
      else
         op.key = {$urandom, $urandom};
      op.value = {$urandom, $urandom};
      return op;
   endfunction

   function automatic void queue_op(logic [1:0] mode, logic [63:0] key, logic [63:0] value);
      map_op_type op;
      op.mode = mode;
      op.key = key;
      op.value = value;
      pending_ops.push_back(op);
   endfunction

   // Hold until every queued item went out and every result came back.
   task automatic drain();
      while (pending_ops.size() != 0 || expected_rsps.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // APB write: setup, then access; upper pwdata bits are don't-care.
   task automatic write_buckets(int unsigned count);
      logic [31:0] word;
      word = {23'($urandom_range(32'h7fffff)), count[8:0]};
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = 1'b0;
      csr_pwdata = word;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      map_buckets = 32'(word[8:0]);
   endtask

   task automatic random_phase(int unsigned count, int unsigned items);
      write_buckets(count);
      repeat (items) pending_ops.push_back(random_map_op());
      drain();
   endtask

   // Driver: present items in bursts with random gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (!req_tvalid || op_taken) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, pending_ops[0].value, pending_ops[0].key,
                             pending_ops[0].mode};
               if (burst_left == 0) begin
                  burst_left = $urandom_range(12, 1);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         op_taken = 1'b0;
         // Receiver stall pattern: switch behavior every so often.
         if ($urandom_range(63) == 0) stall_kind = $urandom_range(2);
         case (stall_kind)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(1));
            default: rsp_tready <= ($urandom_range(7) == 0);
         endcase
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      map_op_type op;
      rsp_type    got;
      rsp_type    want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("chained_hash_map_unit_tb: errors");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         op = pending_ops.pop_front();
         expected_rsps.push_back(apply_map_op(op));
         op_taken = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result_value = rsp_tdata[63:0];
         got.hit = rsp_tdata[64];
         got.pool_full = rsp_tdata[65];
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.result_value !== want.result_value) begin
               $error("result_value: expected %h actual %h", want.result_value,
                      got.result_value);
               error_count++;
            end
            if (got.hit !== want.hit) begin
               $error("hit: expected %b actual %b", want.hit, got.hit);
               error_count++;
            end
            if (got.pool_full !== want.pool_full) begin
               $error("pool_full: expected %b actual %b", want.pool_full, got.pool_full);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 1'b0;
      csr_pwdata = '0;
      error_count = 0;
      cycle_count = 0;
      op_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_kind = 0;
      map_buckets = MaxBuckets;
      map_used = 0;
      foreach (map_heads[i]) map_heads[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: misses, insert-if-absent both ways, shadowing, mode three.
      queue_op(MODE_GET, 64'd0, 64'hffff_ffff_ffff_ffff);
      queue_op(MODE_TRY, 64'd0, 64'h0123_4567_89ab_cdef);
      queue_op(MODE_TRY, 64'd0, 64'hffff_ffff_ffff_ffff);
      queue_op(MODE_GET, 64'd0, 64'd0);
      queue_op(MODE_PUT, 64'd0, 64'hfedc_ba98_7654_3210);
      queue_op(MODE_GET, 64'd0, 64'd0);
      queue_op(MODE_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
      queue_op(MODE_PUT, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_op(MODE_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
      queue_op(MODE_PUT, 64'd256, 64'h0);
      queue_op(MODE_GET, 64'd256, 64'h1);
      queue_op(MODE_GET, 64'd512, 64'h1);
      queue_op(2'd3, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_op(2'd3, 64'd0, 64'd0);
      queue_op(MODE_TRY, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
      queue_op(MODE_TRY, 64'h8000_0000_0000_0000, 64'haaaa_aaaa_aaaa_aaaa);
      drain();

      // Zero buckets behaves as one; 511 saturates; then mixed counts.
      write_buckets(0);
      queue_op(MODE_PUT, 64'd7, 64'd70);
      queue_op(MODE_GET, 64'd7, 64'd0);
      queue_op(MODE_GET, 64'd0, 64'd0);
      drain();
      write_buckets(511);
      queue_op(MODE_GET, 64'd7, 64'd0);
      queue_op(MODE_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
      drain();

      random_phase(1, 60);
      random_phase(7, 300);
      random_phase(256, 700);
      random_phase(1, 40);
      random_phase($urandom_range(256, 1), 400);
      random_phase(256, 430);

      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("chained_hash_map_unit_tb: clean");
      end else begin
         $display("chained_hash_map_unit_tb: errors");
      end
      $finish;
   end
endmodule
